// ===== hdl/ssp_pkg.sv =====
// Package for the servo sweep pulse generator.
// Holds register indexes, reset values and the structs shared by the modules.
// No dependencies.
`default_nettype none

package ssp_pkg;

   localparam int WidthBits = 12;
   localparam int SpeedBits = 8;
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits = 12;

   localparam logic [CsrIndexBits-1:0] CsrPeriodTicks  = 3'd0;
   localparam logic [CsrIndexBits-1:0] CsrWidthMin     = 3'd1;
   localparam logic [CsrIndexBits-1:0] CsrWidthMax     = 3'd2;
   localparam logic [CsrIndexBits-1:0] CsrSpeedSetting = 3'd3;

   localparam logic [WidthBits-1:0] ResetPeriodTicks  = 12'd2000;
   localparam logic [WidthBits-1:0] ResetWidthMin     = 12'd50;
   localparam logic [WidthBits-1:0] ResetWidthMax     = 12'd250;
   localparam logic [SpeedBits-1:0] ResetSpeedSetting = 8'd1;
   localparam logic [WidthBits-1:0] ResetPulseWidth   = 12'd50;

   typedef struct packed {
      logic [WidthBits-1:0] period_ticks;
      logic [WidthBits-1:0] width_min;
      logic [WidthBits-1:0] width_max;
      logic [SpeedBits-1:0] speed_setting;
   } cfg_type;

   typedef struct packed {
      logic                 pulse_level;
      logic                 indicator_level;
      logic [WidthBits-1:0] current_width;
      logic                 sweeping_up;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/servo_sweep_pwm.sv =====
// Top level of the servo sweep pulse generator.
// Depends on ssp_pkg, ssp_csr and ssp_core.
//
// Each accepted item is one timer tick (advance = 1) or a hold (advance = 0),
// and gives exactly one result: drive and indicator levels, the pulse width and
// the sweep direction after that tick. The block takes one item per clock cycle
// while the output register is empty or rsp_ready is high; the result appears in
// the cycle after acceptance in the output register, which may wait for rsp_ready
// while the next item is already taken in its cycle of release. The state update
// is one increment and a few compares. Configuration registers are written
// through the csr_ channel, which is always ready.
`default_nettype none

module servo_sweep_pwm
   import ssp_pkg::*;
#(
   parameter int COUNTER_BITS = 12
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_advance,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_pulse_level,
   output logic                         rsp_indicator_level,
   output logic [WidthBits-1:0]         rsp_current_width,
   output logic                         rsp_sweeping_up,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CsrIndexBits-1:0] csr_index,
   input  wire logic [CsrDataBits-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;

   ssp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssp_core #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_accept),
      .advance (req_advance),
      .cfg     (cfg),
      .result  (result)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_in = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pulse_level = rsp_ff.pulse_level;
   assign rsp_indicator_level = rsp_ff.indicator_level;
   assign rsp_current_width = rsp_ff.current_width;
   assign rsp_sweeping_up = rsp_ff.sweeping_up;

   // Every accepted item shows up as a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   // A held item reports the width that was in place before it.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_advance) |=> (rsp_current_width == $past(u_core.width_ff)))
      else $error("held item reported a different width");

endmodule

`default_nettype wire

// ===== hdl/ssp_csr.sv =====
// Configuration registers of the servo sweep pulse generator.
// Depends on ssp_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module ssp_csr
   import ssp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CsrIndexBits-1:0] csr_index,
   input  wire logic [CsrDataBits-1:0]  csr_wdata,
   output cfg_type                      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CsrPeriodTicks:  cfg_in.period_ticks = csr_wdata[WidthBits-1:0];
            CsrWidthMin:     cfg_in.width_min = csr_wdata[WidthBits-1:0];
            CsrWidthMax:     cfg_in.width_max = csr_wdata[WidthBits-1:0];
            CsrSpeedSetting: cfg_in.speed_setting = csr_wdata[SpeedBits-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_ticks <= ResetPeriodTicks;
         cfg_ff.width_min <= ResetWidthMin;
         cfg_ff.width_max <= ResetWidthMax;
         cfg_ff.speed_setting <= ResetSpeedSetting;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ssp_core.sv =====
// Sweep state and per-tick update of the servo sweep pulse generator.
// Depends on ssp_pkg for cfg_type, result_type and reset values.
`default_nettype none

module ssp_core
   import ssp_pkg::*;
#(
   parameter int COUNTER_BITS = 12
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step_en,
   input  wire logic advance,
   input  cfg_type   cfg,
   output result_type result
);

   localparam int CmpBits = (COUNTER_BITS > WidthBits) ? COUNTER_BITS : WidthBits;

   logic [COUNTER_BITS-1:0] phase_ff, phase_in;
   logic [WidthBits-1:0]    width_ff, width_in;
   logic                    up_ff, up_in;
   logic [SpeedBits-1:0]    div_ff, div_in;
   logic                    drive_ff, drive_in;
   logic                    led_ff, led_in;

   logic [COUNTER_BITS-1:0] phase_inc;
   logic [CmpBits-1:0]      phase_ext;
   logic                    period_end;
   logic [SpeedBits:0]      div_next;
   logic [WidthBits:0]      width_plus;
   logic [WidthBits:0]      min_plus;

   always_comb begin
      phase_in = phase_ff;
      width_in = width_ff;
      up_in = up_ff;
      div_in = div_ff;
      drive_in = drive_ff;
      led_in = led_ff;

      phase_inc = phase_ff + 1'b1;
      phase_ext = CmpBits'(phase_inc);
      period_end = phase_ext >= CmpBits'(cfg.period_ticks);
      div_next = {1'b0, div_ff} + 1'b1;
      width_plus = {1'b0, width_ff} + 1'b1;
      min_plus = {1'b0, cfg.width_min} + 1'b1;

      if (advance) begin
         drive_in = phase_ext < CmpBits'(width_ff);
         led_in = up_ff ? ~drive_in : drive_in;
         phase_in = phase_inc;
         if (period_end) begin
            phase_in = '0;
            if (div_next > {1'b0, cfg.speed_setting}) begin
               div_in = '0;
               // The width clamps on the limit it reaches and the sweep turns there.
               if (up_ff) begin
                  if (width_plus >= {1'b0, cfg.width_max}) begin
                     width_in = cfg.width_max;
                     up_in = 1'b0;
                  end else begin
                     width_in = width_plus[WidthBits-1:0];
                  end
               end else begin
                  if ({1'b0, width_ff} <= min_plus) begin
                     width_in = cfg.width_min;
                     up_in = 1'b1;
                  end else begin
                     width_in = width_ff - 1'b1;
                  end
               end
            end else begin
               div_in = div_next[SpeedBits-1:0];
            end
         end
      end
   end

   assign result.pulse_level = drive_in;
   assign result.indicator_level = led_in;
   assign result.current_width = width_in;
   assign result.sweeping_up = up_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         width_ff <= ResetPulseWidth;
         up_ff <= 1'b1;
         div_ff <= '0;
         drive_ff <= 1'b0;
         led_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         width_ff <= width_in;
         up_ff <= up_in;
         div_ff <= div_in;
         drive_ff <= drive_in;
         led_ff <= led_in;
      end
   end

   // A held tick or an idle cycle leaves the sweep state untouched.
   assert property (@(posedge clock) disable iff (reset)
      (!step_en || !advance) |=> $stable(phase_ff) && $stable(width_ff) && $stable(up_ff)
         && $stable(div_ff))
      else $error("sweep state changed without a tick");

   // The end of a period always restarts the phase.
   assert property (@(posedge clock) disable iff (reset)
      (step_en && advance && period_end) |=> (phase_ff == '0))
      else $error("phase not cleared at end of period");

   // The width only moves at the end of a period.
   assert property (@(posedge clock) disable iff (reset)
      (step_en && advance && !period_end) |=> $stable(width_ff) && $stable(up_ff))
      else $error("width moved inside a period");

endmodule

`default_nettype wire

// ===== dv/servo_sweep_pwm_tb.sv =====
// Self-checking testbench for servo_sweep_pwm: sends ticks and holds, keeps its own
// model of the phase counter, divider and width sweep, and checks every result.
// Depends on ssp_pkg and the servo_sweep_pwm RTL; reads no files.
module servo_sweep_pwm_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ssp_pkg::*;

   localparam int CounterBits = 12;
   localparam int IdlePercent = 38;
   localparam int StallLimit = 1000;
   localparam int HoldOffCycles = 80;
   localparam int PrintLimit = 40;
   localparam int RandomItems = 300;
   localparam logic [CsrIndexBits-1:0] CsrUnusedFirst = 3'd4;
   localparam logic [CsrIndexBits-1:0] CsrUnusedLast = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_advance = 1'b0;
   logic rsp_ready = 1'b0;
   logic csr_valid = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CsrDataBits-1:0] csr_wdata = '0;

   logic req_ready;
   logic rsp_valid;
   logic rsp_pulse_level;
   logic rsp_indicator_level;
   logic [WidthBits-1:0] rsp_current_width;
   logic rsp_sweeping_up;
   logic csr_ready;

   // Model of the sweep generator
   cfg_type sweep_cfg;
   logic [CounterBits-1:0] phase_cnt;
   logic [WidthBits-1:0] width_cnt;
   logic dir_up;
   logic [SpeedBits-1:0] divider_cnt;
   logic drive_lvl;
   logic led_lvl;

   result_type expected_outputs[$];
   int mismatches = 0;
   int stall_cycles = 0;
   int hold_left = 0;
   bit no_idle = 1'b0;
   bit hold_off_request = 1'b0;

   servo_sweep_pwm u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_advance        (req_advance),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pulse_level    (rsp_pulse_level),
      .rsp_indicator_level(rsp_indicator_level),
      .rsp_current_width  (rsp_current_width),
      .rsp_sweeping_up    (rsp_sweeping_up),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void reset_sweep_model();
      sweep_cfg.period_ticks = ResetPeriodTicks;
      sweep_cfg.width_min = ResetWidthMin;
      sweep_cfg.width_max = ResetWidthMax;
      sweep_cfg.speed_setting = ResetSpeedSetting;
      phase_cnt = '0;
      width_cnt = ResetPulseWidth;
      dir_up = 1'b1;
      divider_cnt = '0;
      drive_lvl = 1'b0;
      led_lvl = 1'b0;
   endfunction

   function automatic result_type sweep_tick(input logic adv);
      result_type res;
      logic [SpeedBits:0] div_next;
      int w;
      if (adv) begin
         phase_cnt = phase_cnt + 1'b1;
         drive_lvl = (phase_cnt < width_cnt);
         // The indicator uses the direction held before any step in this tick.
         led_lvl = dir_up ? ~drive_lvl : drive_lvl;
         if (phase_cnt >= sweep_cfg.period_ticks) begin
            div_next = {1'b0, divider_cnt} + 1'b1;
            phase_cnt = '0;
            if (div_next > {1'b0, sweep_cfg.speed_setting}) begin
               divider_cnt = '0;
               w = int'(width_cnt);
               if (dir_up) begin
                  w = w + 1;
                  if (w >= int'(sweep_cfg.width_max)) begin
                     w = int'(sweep_cfg.width_max);
                     dir_up = 1'b0;
                  end
               end else begin
                  w = w - 1;
                  if (w <= int'(sweep_cfg.width_min)) begin
                     w = int'(sweep_cfg.width_min);
                     dir_up = 1'b1;
                  end
               end
               width_cnt = w[WidthBits-1:0];
            end else begin
               divider_cnt = div_next[SpeedBits-1:0];
            end
         end
      end
      res.pulse_level = drive_lvl;
      res.indicator_level = led_lvl;
      res.current_width = width_cnt;
      res.sweeping_up = dir_up;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [WidthBits-1:0] want,
                                       input logic [WidthBits-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= PrintLimit)
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   // Result side: random back-pressure, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_left = HoldOffCycles;
         hold_off_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = no_idle || ($urandom_range(99) >= IdlePercent);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= PrintLimit)
               $display("%0t ns: result with none expected, actual width %0d",
                        $time, rsp_current_width);
         end else begin
            want = expected_outputs.pop_front();
            check_field("pulse_level", WidthBits'(want.pulse_level),
                        WidthBits'(rsp_pulse_level));
            check_field("indicator_level", WidthBits'(want.indicator_level),
                        WidthBits'(rsp_indicator_level));
            check_field("current_width", want.current_width, rsp_current_width);
            check_field("sweeping_up", WidthBits'(want.sweeping_up),
                        WidthBits'(rsp_sweeping_up));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= StallLimit) begin
         $display("%0t ns: no item moved for %0d cycles", $time, StallLimit);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_item(input logic adv);
      @(negedge clock);
      if (!no_idle && $urandom_range(99) < IdlePercent) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_advance = adv;
      do @(posedge clock); while (!req_ready);
      expected_outputs.push_back(sweep_tick(adv));
   endtask

   task automatic send_run(input int count, input int tick_percent);
      repeat (count) send_item($urandom_range(99) < tick_percent);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexBits-1:0] idx,
                                 input logic [CsrDataBits-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CsrPeriodTicks: sweep_cfg.period_ticks = data;
         CsrWidthMin: sweep_cfg.width_min = data;
         CsrWidthMax: sweep_cfg.width_max = data;
         CsrSpeedSetting: sweep_cfg.speed_setting = data[SpeedBits-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(input int period, input int wmin, input int wmax, input int speed);
      write_register(CsrPeriodTicks, period[CsrDataBits-1:0]);
      write_register(CsrWidthMin, wmin[CsrDataBits-1:0]);
      write_register(CsrWidthMax, wmax[CsrDataBits-1:0]);
      write_register(CsrSpeedSetting, speed[CsrDataBits-1:0]);
   endtask

   // Limits a few steps either side of the present width, so the sweep turns often.
   task automatic configure_around(input int period, input int speed);
      int lo;
      int hi;
      lo = int'(width_cnt) - $urandom_range(0, 4);
      hi = int'(width_cnt) + $urandom_range(0, 4);
      if (lo < 0) lo = 0;
      if (hi > 4095) hi = 4095;
      configure(period, lo, hi, speed);
   endtask

   task automatic test_hold_after_reset();
      send_item(1'b0);
      send_item(1'b0);
      send_run(3, 100);
      send_item(1'b0);
      drain_results();
   endtask

   task automatic test_fast_sweep();
      configure(1, 0, 2, 0);
      send_run(7, 100);
      send_item(1'b0);
      send_run(7, 100);
      drain_results();
   endtask

   task automatic test_zero_period_swapped_limits();
      configure(0, 4095, 0, 0);
      send_run(5, 100);
      drain_results();
      // Wide limits after the swap let a downward step fall below zero and clamp.
      write_register(CsrWidthMin, 12'd0);
      write_register(CsrWidthMax, 12'd4095);
      send_run(3, 100);
      drain_results();
   endtask

   task automatic test_unused_index();
      write_register(CsrUnusedFirst, 12'hfff);
      write_register(CsrUnusedLast, 12'h000);
      send_run(3, 100);
      drain_results();
   endtask

   task automatic test_slow_divider();
      // All ones to the speed register: only the low byte is kept, giving 255.
      configure(0, 0, 4095, 12'hfff);
      send_run(260, 100);
      drain_results();
   endtask

   task automatic test_long_period();
      configure(100, 0, 4095, 0);
      send_run(120, 100);
      drain_results();
   endtask

   task automatic test_random_sweeps();
      int sent;
      int count;
      int period;
      int speed;
      sent = 0;
      while (sent < RandomItems) begin
         period = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(0, 4);
         speed = ($urandom_range(5) == 0) ? $urandom_range(255) : $urandom_range(0, 2);
         speed = speed | ($urandom_range(15) << SpeedBits);
         case ($urandom_range(5))
            0: configure(period, $urandom_range(4095), $urandom_range(4095), speed);
            1: configure(period, 0, 4095, speed);
            default: configure_around(period, speed);
         endcase
         count = $urandom_range(40, 120);
         send_run(count, 85);
         sent += count;
         drain_results();
      end
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      configure_around(2, 0);
      send_run(100, 90);
      drain_results();
      no_idle = 1'b0;
   endtask

   task automatic test_output_backpressure();
      configure_around(1, 0);
      hold_off_request = 1'b1;
      send_run(40, 100);
      drain_results();
   endtask

   initial begin
      reset_sweep_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_hold_after_reset();
      test_fast_sweep();
      test_zero_period_swapped_limits();
      test_unused_index();
      test_slow_divider();
      test_long_period();
      test_random_sweeps();
      test_back_to_back();
      test_output_backpressure();

      repeat (4) @(posedge clock);
      if (expected_outputs.size() != 0) begin
         $display("%0t ns: %0d results never arrived", $time, expected_outputs.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
